### hdl/srtl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtl_pkg
// Fixed field widths, item modes and control types shared by the sphere
// region table lookup block.
// ----------------------------------------------------------------------------
package srtl_pkg;

    localparam int MODE_W = 2;
    localparam int ID_W   = 32;
    localparam int MAP_W  = 16;
    localparam int RAD_W  = 20;
    localparam int RSQ_W  = 2 * RAD_W;
    localparam int KIND_W = 2;
    localparam int SLOT_W = 6;
    localparam int CNT_W  = 7;

    localparam logic [KIND_W-1:0] KIND_ANY = '0;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_QUERY  = 2'd3
    } t_mode;

    // Operand source of the square unit
    typedef enum logic {
        SRC_DIFF = 1'b0,
        SRC_RAW  = 1'b1
    } t_src;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } t_acc_op;

    typedef struct packed {
        logic    load;
        t_src    src;
        t_acc_op acc_op;
    } t_sq_ctrl;

endpackage

### hdl/srtl_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtl_in_if
// Input item channel: mode, region id, map, position, radius and kind.
// ----------------------------------------------------------------------------
interface srtl_in_if #(
    parameter int COORD_BITS = 24
) ();
    import srtl_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [MODE_W-1:0]            mode;
    logic [ID_W-1:0]              spot_id;
    logic [MAP_W-1:0]             map_number;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic [RAD_W-1:0]             radius;
    logic [KIND_W-1:0]            spot_kind;

    modport source (
        output valid, mode, spot_id, map_number, pos_x, pos_y, pos_z, radius, spot_kind,
        input  ready
    );

    modport sink (
        input  valid, mode, spot_id, map_number, pos_x, pos_y, pos_z, radius, spot_kind,
        output ready
    );
endinterface

### hdl/srtl_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtl_out_if
// Result item channel: hit flag, id, slot, table full flag and entry count.
// ----------------------------------------------------------------------------
interface srtl_out_if ();
    import srtl_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [ID_W-1:0]   found_id;
    logic [SLOT_W-1:0] found_slot;
    logic              table_full;
    logic [CNT_W-1:0]  entry_count;

    modport source (
        output valid, found, found_id, found_slot, table_full, entry_count,
        input  ready
    );

    modport sink (
        input  valid, found, found_id, found_slot, table_full, entry_count,
        output ready
    );
endinterface

### hdl/srtl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtl_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module srtl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/srtl_sq_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtl_sq_unit
// Shared square-accumulate unit: absolute difference of one axis, square,
// and running sum compared against a stored squared radius.
// ----------------------------------------------------------------------------
module srtl_sq_unit #(
    parameter int COORD_BITS = 24
) (
    input  logic                           i_clk,
    input  srtl_pkg::t_sq_ctrl             i_ctrl,
    input  logic signed [COORD_BITS-1:0]   i_a,
    input  logic signed [COORD_BITS-1:0]   i_b,
    input  logic [srtl_pkg::RAD_W-1:0]     i_raw,
    input  logic [srtl_pkg::RSQ_W-1:0]     i_rsq,
    output logic [srtl_pkg::RSQ_W-1:0]     o_sq,
    output logic                           o_inside
);
    import srtl_pkg::*;

    localparam int MW    = (COORD_BITS > RAD_W) ? COORD_BITS : RAD_W;
    localparam int ACC_W = 2 * MW + 2;

    logic [COORD_BITS:0] w_diff;
    logic [COORD_BITS:0] w_abs;
    logic [MW-1:0]       w_operand;

    logic [MW-1:0]       r_diff;
    logic [2*MW-1:0]     r_prod;
    logic [ACC_W-1:0]    r_acc;

    always_comb begin
        // sign-extend by one bit so the difference cannot overflow
        w_diff = {i_a[COORD_BITS-1], i_a} - {i_b[COORD_BITS-1], i_b};
        w_abs  = w_diff[COORD_BITS] ? (~w_diff + 1'b1) : w_diff;
        if (i_ctrl.src == SRC_RAW) begin
            w_operand = MW'(i_raw);
        end else begin
            w_operand = MW'(w_abs[COORD_BITS-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_diff <= w_operand;
        end
        r_prod <= r_diff * r_diff;
        case (i_ctrl.acc_op)
            ACC_LOAD: r_acc <= ACC_W'(r_prod);
            ACC_ADD:  r_acc <= r_acc + ACC_W'(r_prod);
            default:  r_acc <= r_acc;
        endcase
    end

    assign o_sq     = r_prod[RSQ_W-1:0];
    assign o_inside = (r_acc <= ACC_W'(i_rsq));
endmodule

### hdl/sphere_region_table_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_region_table_lookup
// Ordered table of spherical regions with clear, append, remove-by-id and
// first-hit point query.
// ----------------------------------------------------------------------------
// Items are handled one at a time; the block takes a new item once the last
// one has reached the result register, which may still wait to be taken.
// Append forms the squared radius once in the square unit and stores it with
// the entry. Remove reads one entry per cycle through the single table RAM
// and moves the survivors down over the removed ones. Query scans the entries
// in order; each one that matches map and kind goes through the shared
// square-accumulate unit one axis per cycle, the others are passed over
// without it. An empty table answers without a scan. The table RAM needs no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module sphere_region_table_lookup #(
    parameter int TABLE_DEPTH = 64,
    parameter int COORD_BITS  = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    srtl_in_if.sink       i_in,
    srtl_out_if.source    o_out
);
    import srtl_pkg::*;

    localparam int AIW = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int EW  = ID_W + MAP_W + 3 * COORD_BITS + RSQ_W + KIND_W;

    localparam int KIND_LSB = 0;
    localparam int RSQ_LSB  = KIND_LSB + KIND_W;
    localparam int Z_LSB    = RSQ_LSB + RSQ_W;
    localparam int Y_LSB    = Z_LSB + COORD_BITS;
    localparam int X_LSB    = Y_LSB + COORD_BITS;
    localparam int MAP_LSB  = X_LSB + COORD_BITS;
    localparam int ID_LSB   = MAP_LSB + MAP_W;

    localparam logic [2:0] STEP_Y   = 3'd1;
    localparam logic [2:0] STEP_Z   = 3'd2;
    localparam logic [2:0] STEP_AY  = 3'd3;
    localparam logic [2:0] STEP_AZ  = 3'd4;
    localparam logic [2:0] STEP_CMP = 3'd5;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_APP0 = 7'b0000010,
        S_APP1 = 7'b0000100,
        S_REM  = 7'b0001000,
        S_QCHK = 7'b0010000,
        S_CALC = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // latched item
    logic [ID_W-1:0]              r_id, n_id;
    logic [MAP_W-1:0]             r_map, n_map;
    logic signed [COORD_BITS-1:0] r_qx, n_qx;
    logic signed [COORD_BITS-1:0] r_qy, n_qy;
    logic signed [COORD_BITS-1:0] r_qz, n_qz;
    logic [KIND_W-1:0]            r_kind, n_kind;

    // scan control
    logic [CW-1:0]  r_count, n_count;
    logic [AIW-1:0] r_i, n_i;
    logic [CW-1:0]  r_w, n_w;
    logic [2:0]     r_step, n_step;

    // pending result
    logic              r_found, n_found;
    logic [ID_W-1:0]   r_fid, n_fid;
    logic [SLOT_W-1:0] r_fslot, n_fslot;
    logic              r_full, n_full;

    // result register
    logic              r_out_valid, n_out_valid;
    logic              r_o_found, n_o_found;
    logic [ID_W-1:0]   r_o_id, n_o_id;
    logic [SLOT_W-1:0] r_o_slot, n_o_slot;
    logic              r_o_full, n_o_full;
    logic [CNT_W-1:0]  r_o_count, n_o_count;

    // table RAM
    logic           w_we;
    logic [AIW-1:0] w_waddr;
    logic [EW-1:0]  w_wdata;
    logic           w_re;
    logic [AIW-1:0] w_raddr;
    logic [EW-1:0]  w_rdata;

    // square unit
    t_sq_ctrl                     w_sq_ctrl;
    logic signed [COORD_BITS-1:0] w_sq_a;
    logic signed [COORD_BITS-1:0] w_sq_b;
    logic [RSQ_W-1:0]             w_sq;
    logic                         w_inside;

    // fields of the entry just read
    logic [ID_W-1:0]              f_id;
    logic [MAP_W-1:0]             f_map;
    logic signed [COORD_BITS-1:0] f_x;
    logic signed [COORD_BITS-1:0] f_y;
    logic signed [COORD_BITS-1:0] f_z;
    logic [RSQ_W-1:0]             f_rsq;
    logic [KIND_W-1:0]            f_kind;

    logic w_last;
    logic w_cand;

    assign f_id   = w_rdata[ID_LSB +: ID_W];
    assign f_map  = w_rdata[MAP_LSB +: MAP_W];
    assign f_x    = w_rdata[X_LSB +: COORD_BITS];
    assign f_y    = w_rdata[Y_LSB +: COORD_BITS];
    assign f_z    = w_rdata[Z_LSB +: COORD_BITS];
    assign f_rsq  = w_rdata[RSQ_LSB +: RSQ_W];
    assign f_kind = w_rdata[KIND_LSB +: KIND_W];

    assign w_last = ((CW'(r_i) + CW'(1)) == r_count);
    assign w_cand = (f_map == r_map) && ((r_kind == KIND_ANY) || (f_kind == r_kind));

    srtl_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    srtl_sq_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_sq (
        .i_clk    (i_clk),
        .i_ctrl   (w_sq_ctrl),
        .i_a      (w_sq_a),
        .i_b      (w_sq_b),
        .i_raw    (i_in.radius),
        .i_rsq    (f_rsq),
        .o_sq     (w_sq),
        .o_inside (w_inside)
    );

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_id        = r_id;
        n_map       = r_map;
        n_qx        = r_qx;
        n_qy        = r_qy;
        n_qz        = r_qz;
        n_kind      = r_kind;
        n_count     = r_count;
        n_i         = r_i;
        n_w         = r_w;
        n_step      = r_step;
        n_found     = r_found;
        n_fid       = r_fid;
        n_fslot     = r_fslot;
        n_full      = r_full;
        n_out_valid = r_out_valid & ~o_out.ready;
        n_o_found   = r_o_found;
        n_o_id      = r_o_id;
        n_o_slot    = r_o_slot;
        n_o_full    = r_o_full;
        n_o_count   = r_o_count;

        w_we      = 1'b0;
        w_waddr   = r_w[AIW-1:0];
        w_wdata   = w_rdata;
        w_re      = 1'b0;
        w_raddr   = r_i + AIW'(1);

        w_sq_ctrl = '{load: 1'b0, src: SRC_DIFF, acc_op: ACC_HOLD};
        w_sq_a    = f_x;
        w_sq_b    = r_qx;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_id    = i_in.spot_id;
                    n_map   = i_in.map_number;
                    n_qx    = i_in.pos_x;
                    n_qy    = i_in.pos_y;
                    n_qz    = i_in.pos_z;
                    n_kind  = i_in.spot_kind;
                    n_found = 1'b0;
                    n_fid   = '0;
                    n_fslot = '0;
                    n_full  = 1'b0;
                    n_i     = '0;
                    n_w     = '0;
                    case (t_mode'(i_in.mode))
                        MODE_CLEAR: begin
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        MODE_APPEND: begin
                            if (r_count == CW'(TABLE_DEPTH)) begin
                                n_full  = 1'b1;
                                n_state = S_DONE;
                            end else begin
                                // square the radius once, store it with the entry
                                w_sq_ctrl.load = 1'b1;
                                w_sq_ctrl.src  = SRC_RAW;
                                n_state        = S_APP0;
                            end
                        end
                        MODE_REMOVE, MODE_QUERY: begin
                            if (r_count == '0) begin
                                n_state = S_DONE;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = '0;
                                n_state = (t_mode'(i_in.mode) == MODE_REMOVE) ? S_REM : S_QCHK;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end

            S_APP0: n_state = S_APP1;

            S_APP1: begin
                w_we    = 1'b1;
                w_waddr = r_count[AIW-1:0];
                w_wdata = {r_id, r_map, r_qx, r_qy, r_qz, w_sq, r_kind};
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end

            S_REM: begin
                if (f_id == r_id) begin
                    // drop the entry
                    n_found = 1'b1;
                    n_fid   = r_id;
                end else begin
                    w_we = (CW'(r_i) != r_w);
                    n_w  = r_w + CW'(1);
                end
                if (w_last) begin
                    n_count = n_w;
                    n_state = S_DONE;
                end else begin
                    w_re = 1'b1;
                    n_i  = r_i + AIW'(1);
                end
            end

            S_QCHK: begin
                if (w_cand) begin
                    w_sq_ctrl.load = 1'b1;
                    n_step         = STEP_Y;
                    n_state        = S_CALC;
                end else if (w_last) begin
                    n_state = S_DONE;
                end else begin
                    w_re = 1'b1;
                    n_i  = r_i + AIW'(1);
                end
            end

            S_CALC: begin
                n_step = r_step + 3'd1;
                case (r_step)
                    STEP_Y: begin
                        w_sq_ctrl.load = 1'b1;
                        w_sq_a         = f_y;
                        w_sq_b         = r_qy;
                    end
                    STEP_Z: begin
                        w_sq_ctrl.load   = 1'b1;
                        w_sq_ctrl.acc_op = ACC_LOAD;
                        w_sq_a           = f_z;
                        w_sq_b           = r_qz;
                    end
                    STEP_AY, STEP_AZ: begin
                        w_sq_ctrl.acc_op = ACC_ADD;
                    end
                    STEP_CMP: begin
                        if (w_inside) begin
                            n_found = 1'b1;
                            n_fid   = f_id;
                            n_fslot = SLOT_W'(r_i);
                            n_state = S_DONE;
                        end else if (w_last) begin
                            n_state = S_DONE;
                        end else begin
                            w_re    = 1'b1;
                            n_i     = r_i + AIW'(1);
                            n_state = S_QCHK;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end

            S_DONE: begin
                // hold until the result register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_o_found   = r_found;
                    n_o_id      = r_fid;
                    n_o_slot    = r_fslot;
                    n_o_full    = r_full;
                    n_o_count   = CNT_W'(r_count);
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id      <= n_id;
        r_map     <= n_map;
        r_qx      <= n_qx;
        r_qy      <= n_qy;
        r_qz      <= n_qz;
        r_kind    <= n_kind;
        r_i       <= n_i;
        r_w       <= n_w;
        r_step    <= n_step;
        r_found   <= n_found;
        r_fid     <= n_fid;
        r_fslot   <= n_fslot;
        r_full    <= n_full;
        r_o_found <= n_o_found;
        r_o_id    <= n_o_id;
        r_o_slot  <= n_o_slot;
        r_o_full  <= n_o_full;
        r_o_count <= n_o_count;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_o_found;
    assign o_out.found_id    = r_o_id;
    assign o_out.found_slot  = r_o_slot;
    assign o_out.table_full  = r_o_full;
    assign o_out.entry_count = r_o_count;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_APP1 || r_state == S_REM))
        else $error("table write outside append or remove");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REM) |-> (r_w <= CW'(r_i)))
        else $error("remove write pointer passed read pointer");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> (r_step >= STEP_Y && r_step <= STEP_CMP))
        else $error("distance step out of range");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");
`endif
endmodule

### verif/srtl_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtl_result_checker
// Watches the item and result channels of the sphere region table lookup.
// Keeps its own copy of the region table, works out the answer to every
// accepted item and compares each accepted result field by field with the
// oldest answer still waiting.
// ----------------------------------------------------------------------------
module srtl_result_checker #(
    parameter int TABLE_DEPTH = 64,
    parameter int COORD_BITS  = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    srtl_in_if   i_in_mon,
    srtl_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import srtl_pkg::*;

    typedef struct packed {
        logic              found;
        logic [ID_W-1:0]   found_id;
        logic [SLOT_W-1:0] found_slot;
        logic              table_full;
        logic [CNT_W-1:0]  entry_count;
    } t_region_answer;

    logic [ID_W-1:0]       tbl_id     [TABLE_DEPTH];
    logic [MAP_W-1:0]      tbl_map    [TABLE_DEPTH];
    logic [COORD_BITS-1:0] tbl_x      [TABLE_DEPTH];
    logic [COORD_BITS-1:0] tbl_y      [TABLE_DEPTH];
    logic [COORD_BITS-1:0] tbl_z      [TABLE_DEPTH];
    logic [RAD_W-1:0]      tbl_radius [TABLE_DEPTH];
    logic [KIND_W-1:0]     tbl_kind   [TABLE_DEPTH];
    int                    tbl_used = 0;

    t_region_answer expected_answers[$];
    int             fail_total = 0;

    function automatic longint unsigned axis_sq(input logic [COORD_BITS-1:0] a,
                                                input logic [COORD_BITS-1:0] b);
        longint d;
        d = longint'(signed'(a)) - longint'(signed'(b));
        return d * d;
    endfunction

    task automatic predict_lookup(input t_mode mode, input logic [ID_W-1:0] id,
                                  input logic [MAP_W-1:0] map,
                                  input logic [COORD_BITS-1:0] x,
                                  input logic [COORD_BITS-1:0] y,
                                  input logic [COORD_BITS-1:0] z,
                                  input logic [RAD_W-1:0] radius,
                                  input logic [KIND_W-1:0] kind,
                                  output t_region_answer ans);
        int                kept;
        longint unsigned   dist_sq;
        longint unsigned   rad_sq;
        ans = '0;
        case (mode)
            MODE_CLEAR: begin
                tbl_used = 0;
            end
            MODE_APPEND: begin
                if (tbl_used >= TABLE_DEPTH) begin
                    ans.table_full = 1'b1;
                end else begin
                    tbl_id[tbl_used]     = id;
                    tbl_map[tbl_used]    = map;
                    tbl_x[tbl_used]      = x;
                    tbl_y[tbl_used]      = y;
                    tbl_z[tbl_used]      = z;
                    tbl_radius[tbl_used] = radius;
                    tbl_kind[tbl_used]   = kind;
                    tbl_used++;
                end
            end
            MODE_REMOVE: begin
                kept = 0;
                // compact the survivors toward slot 0, keeping their order
                for (int i = 0; i < tbl_used; i++) begin
                    if (tbl_id[i] == id) begin
                        ans.found = 1'b1;
                    end else begin
                        tbl_id[kept]     = tbl_id[i];
                        tbl_map[kept]    = tbl_map[i];
                        tbl_x[kept]      = tbl_x[i];
                        tbl_y[kept]      = tbl_y[i];
                        tbl_z[kept]      = tbl_z[i];
                        tbl_radius[kept] = tbl_radius[i];
                        tbl_kind[kept]   = tbl_kind[i];
                        kept++;
                    end
                end
                tbl_used = kept;
                if (ans.found) begin
                    ans.found_id = id;
                end
            end
            MODE_QUERY: begin
                for (int i = 0; i < tbl_used && !ans.found; i++) begin
                    if (tbl_map[i] == map && (kind == KIND_ANY || kind == tbl_kind[i])) begin
                        dist_sq = axis_sq(tbl_x[i], x) + axis_sq(tbl_y[i], y)
                                + axis_sq(tbl_z[i], z);
                        rad_sq  = longint'(tbl_radius[i]) * longint'(tbl_radius[i]);
                        if (dist_sq <= rad_sq) begin
                            ans.found      = 1'b1;
                            ans.found_id   = tbl_id[i];
                            ans.found_slot = i[SLOT_W-1:0];
                        end
                    end
                end
            end
            default: ;
        endcase
        ans.entry_count = tbl_used[CNT_W-1:0];
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            fail_total++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_region_answer ans;
        t_region_answer got;
        if (!i_rst_n) begin
            tbl_used = 0;
            expected_answers.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                predict_lookup(t_mode'(i_in_mon.mode), i_in_mon.spot_id, i_in_mon.map_number,
                               i_in_mon.pos_x, i_in_mon.pos_y, i_in_mon.pos_z,
                               i_in_mon.radius, i_in_mon.spot_kind, ans);
                expected_answers = {expected_answers, ans};
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = '{i_out_mon.found, i_out_mon.found_id, i_out_mon.found_slot,
                        i_out_mon.table_full, i_out_mon.entry_count};
                if (expected_answers.size() == 0) begin
                    fail_total++;
                    $display("%0t: result with no item waiting, expected none, actual 0x%0h",
                             $time, got);
                end else begin
                    ans = expected_answers.pop_front();
                    check_field("found",       32'(ans.found),       32'(got.found));
                    check_field("found_id",    ans.found_id,         got.found_id);
                    check_field("found_slot",  32'(ans.found_slot),  32'(got.found_slot));
                    check_field("table_full",  32'(ans.table_full),  32'(got.table_full));
                    check_field("entry_count", 32'(ans.entry_count), 32'(got.entry_count));
                end
            end
        end
        o_pending    <= expected_answers.size();
        o_fail_count <= fail_total;
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the sphere region table lookup with a short directed sequence and
// then segments of random items aimed at stored regions, with random gaps on
// both channels and one long result hold-off. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import srtl_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int COORD_BITS   = 24;
    localparam int RANDOM_ITEMS = 850;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 600;

    localparam logic [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] CMAX = ~CMIN;
    localparam logic [RAD_W-1:0]      RMAX = '1;

    typedef enum int {
        SEG_FILL  = 0,
        SEG_MIX   = 1,
        SEG_QUERY = 2,
        SEG_DRAIN = 3
    } t_segment;

    // cumulative mode thresholds per segment: append, query, remove; rest clear
    localparam int APPEND_PCT [4] = '{80, 35, 15, 20};
    localparam int QUERY_PCT  [4] = '{95, 80, 90, 60};
    localparam int REMOVE_PCT [4] = '{99, 97, 98, 97};

    typedef struct packed {
        t_mode                 mode;
        logic [ID_W-1:0]       spot_id;
        logic [MAP_W-1:0]      map_number;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [COORD_BITS-1:0] pos_z;
        logic [RAD_W-1:0]      radius;
        logic [KIND_W-1:0]     spot_kind;
    } t_region_item;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   quiet_phase = 1'b0;

    // recently appended regions, used only to aim queries and removes
    logic [ID_W-1:0]       aim_id   [TABLE_DEPTH];
    logic [MAP_W-1:0]      aim_map  [TABLE_DEPTH];
    logic [COORD_BITS-1:0] aim_x    [TABLE_DEPTH];
    logic [COORD_BITS-1:0] aim_y    [TABLE_DEPTH];
    logic [COORD_BITS-1:0] aim_z    [TABLE_DEPTH];
    logic [RAD_W-1:0]      aim_r    [TABLE_DEPTH];
    logic [KIND_W-1:0]     aim_kind [TABLE_DEPTH];
    int                    aim_n  = 0;
    int                    aim_wr = 0;

    logic [MAP_W-1:0] map_pool [3];
    logic [ID_W-1:0]  id_pool  [4];

    srtl_in_if #(.COORD_BITS(COORD_BITS)) in_ch ();
    srtl_out_if out_ch ();

    sphere_region_table_lookup #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    srtl_result_checker #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_region_item pack_item(input t_mode m, input logic [ID_W-1:0] id,
                                               input logic [MAP_W-1:0] map,
                                               input logic [COORD_BITS-1:0] x,
                                               input logic [COORD_BITS-1:0] y,
                                               input logic [COORD_BITS-1:0] z,
                                               input logic [RAD_W-1:0] r,
                                               input logic [KIND_W-1:0] kind);
        return '{m, id, map, x, y, z, r, kind};
    endfunction

    function automatic int spread(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [MAP_W-1:0] rand_map();
        return MAP_W'($urandom);
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_coord();
        return COORD_BITS'($urandom);
    endfunction

    function automatic logic [RAD_W-1:0] rand_radius();
        return RAD_W'($urandom);
    endfunction

    function automatic logic [KIND_W-1:0] rand_kind();
        return KIND_W'($urandom);
    endfunction

    function automatic logic [MAP_W-1:0] pick_map();
        if ($urandom_range(0, 9) < 7) begin
            return map_pool[$urandom_range(0, 2)];
        end
        return rand_map();
    endfunction

    function automatic t_region_item random_item(input t_segment seg);
        t_region_item it;
        int           pick;
        int           k;
        int           r;
        int           delta;
        pick = $urandom_range(0, 99);
        it = pack_item(MODE_CLEAR, $urandom, pick_map(), rand_coord(), rand_coord(),
                       rand_coord(), rand_radius(), rand_kind());
        if (pick < APPEND_PCT[seg]) begin
            it.mode = MODE_APPEND;
            if ($urandom_range(0, 9) < 3) begin
                it.spot_id = id_pool[$urandom_range(0, 3)];
            end
            // crowd half the regions near the origin so that they overlap
            if ($urandom_range(0, 1) == 1) begin
                it.pos_x  = COORD_BITS'(spread(20000));
                it.pos_y  = COORD_BITS'(spread(20000));
                it.pos_z  = COORD_BITS'(spread(20000));
                it.radius = RAD_W'($urandom_range(0, 30000));
            end else if ($urandom_range(0, 1) == 1) begin
                it.radius = RAD_W'($urandom_range(0, 4095));
            end
        end else if (pick < QUERY_PCT[seg]) begin
            it.mode = MODE_QUERY;
            if (aim_n > 0 && $urandom_range(0, 99) < 65) begin
                k = $urandom_range(0, aim_n - 1);
                r = int'(aim_r[k]);
                it.map_number = aim_map[k];
                case ($urandom_range(0, 3))
                    0, 1:    it.spot_kind = aim_kind[k];
                    2:       it.spot_kind = KIND_ANY;
                    default: it.spot_kind = rand_kind();
                endcase
                if ($urandom_range(0, 9) < 7) begin
                    it.pos_x = COORD_BITS'(aim_x[k] + spread(r / 2));
                    it.pos_y = COORD_BITS'(aim_y[k] + spread(r / 2));
                    it.pos_z = COORD_BITS'(aim_z[k] + spread(r / 2));
                end else begin
                    // land on the sphere or just past it along one axis
                    delta = r + int'($urandom_range(0, 1));
                    if ($urandom_range(0, 1) == 1) begin
                        delta = -delta;
                    end
                    it.pos_x = aim_x[k];
                    it.pos_y = aim_y[k];
                    it.pos_z = aim_z[k];
                    case ($urandom_range(0, 2))
                        0:       it.pos_x = COORD_BITS'(aim_x[k] + delta);
                        1:       it.pos_y = COORD_BITS'(aim_y[k] + delta);
                        default: it.pos_z = COORD_BITS'(aim_z[k] + delta);
                    endcase
                end
            end
        end else if (pick < REMOVE_PCT[seg]) begin
            it.mode = MODE_REMOVE;
            if (aim_n > 0 && $urandom_range(0, 9) < 7) begin
                it.spot_id = aim_id[$urandom_range(0, aim_n - 1)];
            end else if ($urandom_range(0, 1) == 1) begin
                it.spot_id = id_pool[$urandom_range(0, 3)];
            end
        end
        return it;
    endfunction

    task automatic send_item(input t_region_item it);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= it.mode;
        in_ch.spot_id    <= it.spot_id;
        in_ch.map_number <= it.map_number;
        in_ch.pos_x      <= it.pos_x;
        in_ch.pos_y      <= it.pos_y;
        in_ch.pos_z      <= it.pos_z;
        in_ch.radius     <= it.radius;
        in_ch.spot_kind  <= it.spot_kind;
        @(posedge i_clk);
        while (!(in_ch.valid && in_ch.ready)) @(posedge i_clk);
        if (it.mode == MODE_APPEND) begin
            aim_id[aim_wr]   = it.spot_id;
            aim_map[aim_wr]  = it.map_number;
            aim_x[aim_wr]    = it.pos_x;
            aim_y[aim_wr]    = it.pos_y;
            aim_z[aim_wr]    = it.pos_z;
            aim_r[aim_wr]    = it.radius;
            aim_kind[aim_wr] = it.spot_kind;
            aim_wr = (aim_wr + 1) % TABLE_DEPTH;
            if (aim_n < TABLE_DEPTH) begin
                aim_n++;
            end
        end
    endtask

    initial begin : stimulus
        int          sent;
        int          seg_len;
        t_segment    seg;
        logic [ID_W-1:0]  dup_id;
        logic [MAP_W-1:0] dir_map;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.mode       <= MODE_CLEAR;
        in_ch.spot_id    <= '0;
        in_ch.map_number <= '0;
        in_ch.pos_x      <= '0;
        in_ch.pos_y      <= '0;
        in_ch.pos_z      <= '0;
        in_ch.radius     <= '0;
        in_ch.spot_kind  <= '0;
        foreach (map_pool[i]) map_pool[i] = rand_map();
        foreach (id_pool[i]) id_pool[i] = $urandom;
        dup_id  = id_pool[0];
        dir_map = map_pool[0];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: query misses, remove finds nothing
        send_item(pack_item(MODE_QUERY, $urandom, dir_map, 0, 0, 0, rand_radius(), KIND_ANY));
        send_item(pack_item(MODE_REMOVE, dup_id, rand_map(), rand_coord(), rand_coord(),
                            rand_coord(), rand_radius(), rand_kind()));
        // extreme regions
        send_item(pack_item(MODE_APPEND, '0, '0, CMIN, CMIN, CMIN, RMAX, KIND_ANY));
        send_item(pack_item(MODE_APPEND, '1, '1, CMAX, CMAX, CMAX, '0, 2'd3));
        // two regions with one id, overlapping, of different kinds
        send_item(pack_item(MODE_APPEND, dup_id, dir_map, 0, 0, 0, 100, 2'd1));
        send_item(pack_item(MODE_APPEND, dup_id, dir_map, 50, 0, 0, 100, 2'd2));
        // exactly on the first sphere, then just outside it under each filter
        send_item(pack_item(MODE_QUERY, $urandom, dir_map, 100, 0, 0, rand_radius(),
                            KIND_ANY));
        send_item(pack_item(MODE_QUERY, $urandom, dir_map, 101, 0, 0, rand_radius(), 2'd1));
        send_item(pack_item(MODE_QUERY, $urandom, dir_map, 101, 0, 0, rand_radius(), 2'd2));
        send_item(pack_item(MODE_QUERY, $urandom, dir_map, 101, 0, 0, rand_radius(),
                            KIND_ANY));
        // zero radius: only the centre itself hits
        send_item(pack_item(MODE_QUERY, $urandom, '1, CMAX, CMAX, CMAX, rand_radius(), 2'd3));
        send_item(pack_item(MODE_QUERY, $urandom, '1, CMAX - 1, CMAX, CMAX, rand_radius(),
                            2'd3));
        // widest distance, then the rim of the largest sphere
        send_item(pack_item(MODE_QUERY, $urandom, '0, CMAX, CMAX, CMAX, rand_radius(),
                            KIND_ANY));
        send_item(pack_item(MODE_QUERY, $urandom, '0, CMIN + RMAX, CMIN, CMIN, rand_radius(),
                            KIND_ANY));
        send_item(pack_item(MODE_QUERY, $urandom, '0, CMIN + RMAX, CMIN, CMIN, rand_radius(),
                            2'd1));
        // remove both entries sharing an id, then an id that is absent
        send_item(pack_item(MODE_REMOVE, dup_id, rand_map(), rand_coord(), rand_coord(),
                            rand_coord(), rand_radius(), rand_kind()));
        send_item(pack_item(MODE_QUERY, $urandom, dir_map, 100, 0, 0, rand_radius(),
                            KIND_ANY));
        send_item(pack_item(MODE_REMOVE, 32'h0000_3039, rand_map(), rand_coord(),
                            rand_coord(), rand_coord(), rand_radius(), rand_kind()));
        send_item(pack_item(MODE_CLEAR, $urandom, rand_map(), rand_coord(), rand_coord(),
                            rand_coord(), rand_radius(), rand_kind()));
        send_item(pack_item(MODE_QUERY, $urandom, '0, CMIN, CMIN, CMIN, rand_radius(),
                            KIND_ANY));
        send_item(pack_item(MODE_APPEND, '1, dir_map, CMIN, CMAX, 0, RMAX, 2'd2));
        send_item(pack_item(MODE_QUERY, $urandom, dir_map, CMIN, CMAX, 0, rand_radius(),
                            2'd2));
        send_item(pack_item(MODE_REMOVE, '1, rand_map(), rand_coord(), rand_coord(),
                            rand_coord(), rand_radius(), rand_kind()));

        // random segments; the first one is mostly appends, to fill the table
        sent = 0;
        seg  = SEG_FILL;
        while (sent < RANDOM_ITEMS) begin
            seg_len     = $urandom_range(40, 100);
            quiet_phase = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < seg_len && sent < RANDOM_ITEMS; n++) begin
                send_item(random_item(seg));
                sent++;
            end
            seg = t_segment'($urandom_range(0, 3));
        end
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = quiet_phase ? 0 : $urandom_range(0, 17);
            // hold off once for long enough that the block backs up its input
            if (taken == HOLD_AT) begin
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_ch.valid && out_ch.ready)) @(posedge i_clk);
            taken++;
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
